### src/kvsw_pkg.sv
// Shared constants, codes and bundle types of the KV cache slice write addresser.
package kvsw_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int MAX_OUTER = 64;
  localparam int ELEM_BITS = 16;

  localparam int DIM_W      = 13;
  localparam int OUTER_W    = 7;
  localparam int POS_W      = 12;
  localparam int IDX_W      = 12;
  localparam int OIDX_W     = $clog2(MAX_OUTER);
  localparam int ADDR_W     = 30;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int Q_DEPTH    = 2;
  localparam int SETTLE_W   = 2;

  localparam logic [DATA_W-1:0] DATA_MASK = DATA_W'((64'd1 << ELEM_BITS) - 64'd1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HIDDEN = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_DIM_SECOND_LAST = 3'd0,
    REG_CACHE_DIM_LAST        = 3'd1,
    REG_SLICE_DIM_SECOND_LAST = 3'd2,
    REG_SLICE_DIM_LAST        = 3'd3,
    REG_OUTER_COUNT           = 3'd4,
    REG_START_POSITION        = 3'd5
  } cfg_reg_t;

  // Geometry derived from the registers, consumed by the front end.
  typedef struct packed {
    status_t             status;
    logic                slice_tr;
    logic [DIM_W-1:0]    hid;
    logic [DIM_W-1:0]    seq_s;
    logic [OUTER_W-1:0]  outer_cnt;
    logic [ADDR_W-1:0]   stride_s;
    logic [ADDR_W-1:0]   stride_h;
    logic [ADDR_W-1:0]   area;
    logic [ADDR_W-1:0]   base_off;
  } kvsw_geom_t;

  // One result beat as held in the queue.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              we;
    status_t           status;
    logic              last;
  } kvsw_beat_t;

endpackage

### src/kvsw_cfg.sv
// Configuration registers and the two-stage geometry derivation.
module kvsw_cfg import kvsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output kvsw_geom_t            geom,
  output logic                  settled
);

  logic [DIM_W-1:0]   c2, c1, s2, s1;
  logic [OUTER_W-1:0] outer_count;
  logic [POS_W-1:0]   start_position;
  logic [SETTLE_W-1:0] settle;

  // stage 1
  logic [DIM_W-1:0]   hid_c, seq_c_c, seq_s_c;
  logic               cache_tr_c, slice_tr_c, dims_ok_c;
  status_t            st1_c;
  logic [DIM_W-1:0]   hid1, seq_c1, seq_s1;
  logic               cache_tr1, slice_tr1;
  status_t            st1;
  logic [OUTER_W-1:0] outer1;
  logic [POS_W-1:0]   start1;
  logic               over_c;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    dim_ok = (d != '0) && (d <= DIM_W'(MAX_DIM));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      c2             <= DIM_W'(1);
      c1             <= DIM_W'(1);
      s2             <= DIM_W'(1);
      s1             <= DIM_W'(1);
      outer_count    <= OUTER_W'(1);
      start_position <= '0;
      settle         <= '1;
    end else begin
      if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CACHE_DIM_SECOND_LAST: begin c2 <= cfg_data; settle <= '1; end
          REG_CACHE_DIM_LAST:        begin c1 <= cfg_data; settle <= '1; end
          REG_SLICE_DIM_SECOND_LAST: begin s2 <= cfg_data; settle <= '1; end
          REG_SLICE_DIM_LAST:        begin s1 <= cfg_data; settle <= '1; end
          REG_OUTER_COUNT: begin
            outer_count <= cfg_data[OUTER_W-1:0];
            settle      <= '1;
          end
          REG_START_POSITION: begin
            start_position <= cfg_data[POS_W-1:0];
            settle         <= '1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign settled = (settle == '0);

  always_comb begin
    hid_c      = (c1 < c2) ? c1 : c2;
    seq_c_c    = (c1 < c2) ? c2 : c1;
    cache_tr_c = (c1 == seq_c_c);
    dims_ok_c  = dim_ok(c1) && dim_ok(c2) && dim_ok(s1) && dim_ok(s2) &&
                 (outer_count != '0) && (outer_count <= OUTER_W'(MAX_OUTER));
    slice_tr_c = 1'b0;
    seq_s_c    = '0;
    st1_c      = ST_OK;
    if (!dims_ok_c) begin
      st1_c = ST_RANGE;
    end else if (s1 == hid_c) begin
      seq_s_c = s2;
    end else if (s2 == hid_c) begin
      slice_tr_c = 1'b1;
      seq_s_c    = s1;
    end else begin
      st1_c = ST_NO_HIDDEN;
    end
  end

  always_ff @(posedge clk) begin
    hid1      <= hid_c;
    seq_c1    <= seq_c_c;
    seq_s1    <= seq_s_c;
    cache_tr1 <= cache_tr_c;
    slice_tr1 <= slice_tr_c;
    st1       <= st1_c;
    outer1    <= outer_count;
    start1    <= start_position;
  end

  // stage 2: range check and address strides
  assign over_c = ({2'b00, start1} + {1'b0, seq_s1}) > {1'b0, seq_c1};

  always_ff @(posedge clk) begin
    geom.status    <= (st1 == ST_OK && over_c) ? ST_RANGE : st1;
    geom.slice_tr  <= slice_tr1;
    geom.hid       <= hid1;
    geom.seq_s     <= seq_s1;
    geom.outer_cnt <= outer1;
    geom.area      <= ADDR_W'(seq_c1) * ADDR_W'(hid1);
    geom.base_off  <= cache_tr1 ? ADDR_W'(start1) : ADDR_W'(start1) * ADDR_W'(hid1);
    geom.stride_s  <= cache_tr1 ? ADDR_W'(1) : ADDR_W'(hid1);
    geom.stride_h  <= cache_tr1 ? ADDR_W'(seq_c1) : ADDR_W'(1);
  end

endmodule

### src/kvsw_front.sv
// Front end: element counters and incremental cache address, one beat per cycle while inputs are accepted.
module kvsw_front import kvsw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  kvsw_geom_t        geom,
  input  logic              settled,
  input  logic              accept,
  input  logic [DATA_W-1:0] elem_data,
  output kvsw_beat_t        beat
);

  logic [OIDX_W-1:0] o;
  logic [IDX_W-1:0]  s, h;
  logic [ADDR_W-1:0] t_o, t_s, t_h;
  logic              o_last, s_last, h_last, last, ok;

  assign ok     = (geom.status == ST_OK);
  assign o_last = (OUTER_W'(o) + OUTER_W'(1)) >= geom.outer_cnt;
  assign s_last = (DIM_W'(s) + DIM_W'(1)) >= geom.seq_s;
  assign h_last = (DIM_W'(h) + DIM_W'(1)) >= geom.hid;
  assign last   = o_last && s_last && h_last;

  always_comb begin
    beat.data = elem_data & DATA_MASK;
    if (ok) begin
      beat.addr   = t_o + t_s + t_h;
      beat.we     = 1'b1;
      beat.status = ST_OK;
      beat.last   = last;
    end else begin
      beat.addr   = '0;
      beat.we     = 1'b0;
      beat.status = geom.status;
      beat.last   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || !settled || (accept && (!ok || last))) begin
      o   <= '0;
      s   <= '0;
      h   <= '0;
      t_o <= '0;
      t_s <= geom.base_off;
      t_h <= '0;
    end else if (accept) begin
      if (!geom.slice_tr) begin
        // hidden fastest, then sequence, then outer
        if (!h_last) begin
          h   <= h + IDX_W'(1);
          t_h <= t_h + geom.stride_h;
        end else begin
          h   <= '0;
          t_h <= '0;
          if (!s_last) begin
            s   <= s + IDX_W'(1);
            t_s <= t_s + geom.stride_s;
          end else begin
            s   <= '0;
            t_s <= geom.base_off;
            o   <= o + OIDX_W'(1);
            t_o <= t_o + geom.area;
          end
        end
      end else begin
        // sequence fastest, then hidden, then outer
        if (!s_last) begin
          s   <= s + IDX_W'(1);
          t_s <= t_s + geom.stride_s;
        end else begin
          s   <= '0;
          t_s <= geom.base_off;
          if (!h_last) begin
            h   <= h + IDX_W'(1);
            t_h <= t_h + geom.stride_h;
          end else begin
            h   <= '0;
            t_h <= '0;
            o   <= o + OIDX_W'(1);
            t_o <= t_o + geom.area;
          end
        end
      end
    end
  end

endmodule

### src/kvsw_queue.sv
// Short result queue between front end and output port; head drives the outputs.
module kvsw_queue import kvsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  kvsw_beat_t push_beat,
  output logic       not_full,
  output logic       head_valid,
  input  logic       pop_ready,
  output kvsw_beat_t head_beat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  kvsw_beat_t        mem [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign not_full   = (count != CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign pop        = head_valid && pop_ready;
  assign head_beat  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/kv_cache_slice_write_addresser.sv
// Top level of the KV cache slice write addresser.
//
// Streams the elements of one new key or value slice, in slice memory order,
// and turns each input beat into one write beat: the cache element address,
// the element bits, a write enable and a status. The hidden size is the
// smaller of the two cache dimensions, the cache sequence length the larger;
// a square cache counts as transposed. The slice counts as [seq, hidden] when
// its last dimension equals the hidden size, else as [hidden, seq] when its
// second to last one does. If neither matches, status is 1 and nothing is
// written; if start_position plus the slice length passes the cache sequence
// length, or a register holds an illegal value, status is 2. Error beats carry
// address 0 and last_elem 0. last_elem marks the final element, after which
// the counters restart for the next slice. Rate: one element per cycle,
// sustained while out_ready stays high; with the queue empty, an accepted
// element reaches the output in the next cycle. Running stride sums give the
// addresses, so no multiply sits in the element path. A write to any of the
// six registers restarts the slice and holds in_ready low while the geometry
// (two register stages with 13x13 and 12x13 multiplies for the outer stride
// and start offset) settles; likewise after reset. Write configuration only
// while no beats are outstanding. A two-entry queue decouples in_ready from
// out_ready, so the input side keeps going while a result waits.
module kv_cache_slice_write_addresser import kvsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     elem_data,
  // output beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     cache_addr,
  output logic [DATA_W-1:0]     write_data,
  output logic                  write_enable,
  output logic [1:0]            status,
  output logic                  last_elem
);

  kvsw_geom_t geom;
  kvsw_beat_t front_beat, head_beat;
  logic       settled, q_not_full, accept;

  assign in_ready = settled && q_not_full;
  assign accept   = in_valid && in_ready;

  kvsw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .settled   (settled)
  );

  kvsw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .settled   (settled),
    .accept    (accept),
    .elem_data (elem_data),
    .beat      (front_beat)
  );

  kvsw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_beat  (front_beat),
    .not_full   (q_not_full),
    .head_valid (out_valid),
    .pop_ready  (out_ready),
    .head_beat  (head_beat)
  );

  assign cache_addr   = head_beat.addr;
  assign write_data   = head_beat.data;
  assign write_enable = head_beat.we;
  assign status       = head_beat.status;
  assign last_elem    = head_beat.last;

endmodule
